// ===== hdl/dops_pkg.sv =====
// ----------------------------------------------------------------------------
// dops_pkg
// Shared widths, action codes, register indexes and the per-channel control
// bundle for the delayed-off power switch.
// ----------------------------------------------------------------------------
package dops_pkg;

    localparam int NUM_CHANNELS_DEF = 6;
    localparam int MASK_W           = 6;
    localparam int CNT_W            = 16;
    localparam int TARGET_W         = 3;
    localparam int KIND_W           = 2;
    localparam int S_TDATA_W        = 8;
    localparam int M_TDATA_W        = 16;
    localparam int CFG_ADDR_W       = 1;
    localparam int CFG_DATA_W       = 16;

    localparam logic [KIND_W-1:0] ACT_OFF     = 2'd0;
    localparam logic [KIND_W-1:0] ACT_ON      = 2'd1;
    localparam logic [KIND_W-1:0] ACT_TOGGLE  = 2'd2;
    localparam logic [KIND_W-1:0] ACT_INVALID = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] REG_DELAY_MASK = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_OFF_DELAY  = 1'd1;

    localparam logic [MASK_W-1:0] DELAY_MASK_RST = 6'd1;
    localparam logic [CNT_W-1:0]  OFF_DELAY_RST  = 16'd60;

    typedef struct packed {
        logic              tick;
        logic              hit;
        logic [KIND_W-1:0] kind;
    } chan_ctl_t;

endpackage

// ===== hdl/delayed_off_power_switch.sv =====
// ----------------------------------------------------------------------------
// delayed_off_power_switch
// Power outputs with per-channel delayed off and a one-second tick input.
// ----------------------------------------------------------------------------
// One item per clock while m_tready is high. An accepted item lands in the
// input register, is applied to all channels in parallel as it moves into the
// result register, and its masks then show on m_tdata with m_tvalid. That move
// happens only when the result register is free or being drained, so m_tready
// low stalls the input after at most two items are held.
module delayed_off_power_switch #(
    parameter int NUM_CHANNELS = dops_pkg::NUM_CHANNELS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [dops_pkg::S_TDATA_W-1:0]      s_tdata,     // target[2:0], action_kind[4:3]
    input  logic                                s_tuser,     // tick
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dops_pkg::M_TDATA_W-1:0]      m_tdata,     // out_mask[5:0], led_mask[11:6]
    input  logic                                cfg_wr_en,
    input  logic [dops_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [dops_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

    logic [dops_pkg::MASK_W-1:0]   delay_mask_reg;
    logic [dops_pkg::CNT_W-1:0]    off_delay_reg;

    logic                          in_valid_reg;
    logic                          in_tick_reg;
    logic [dops_pkg::TARGET_W-1:0] in_target_reg;
    logic [dops_pkg::KIND_W-1:0]   in_kind_reg;

    logic                          m_valid_reg;
    logic [dops_pkg::MASK_W-1:0]   out_mask_reg;

    logic                          advance;
    logic                          target_ok;
    logic [NUM_CHANNELS-1:0]       out_next;
    logic [dops_pkg::MASK_W-1:0]   out_mask_next;

    assign advance   = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign target_ok = (32'(in_target_reg) < NUM_CHANNELS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_mask_reg <= dops_pkg::DELAY_MASK_RST;
            off_delay_reg  <= dops_pkg::OFF_DELAY_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                dops_pkg::REG_DELAY_MASK: delay_mask_reg <= cfg_wr_data[dops_pkg::MASK_W-1:0];
                dops_pkg::REG_OFF_DELAY:  off_delay_reg  <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_tick_reg   <= s_tuser;
            in_target_reg <= s_tdata[dops_pkg::TARGET_W-1:0];
            in_kind_reg   <= s_tdata[dops_pkg::TARGET_W +: dops_pkg::KIND_W];
        end
    end

    genvar i;
    generate
        for (i = 0; i < NUM_CHANNELS; i++) begin : g_chan
            localparam logic [dops_pkg::TARGET_W-1:0] CH_IDX = dops_pkg::TARGET_W'(i);
            dops_pkg::chan_ctl_t ctl;
            logic                delayed;

            assign ctl.tick = in_tick_reg;
            assign ctl.hit  = target_ok && (in_target_reg == CH_IDX);
            assign ctl.kind = in_kind_reg;

            if (i < dops_pkg::MASK_W) begin : g_dly
                assign delayed = delay_mask_reg[i];
            end else begin : g_nodly
                assign delayed = 1'b0;
            end

            dops_chan u_chan (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .en        (advance),
                .ctl       (ctl),
                .delayed   (delayed),
                .off_delay (off_delay_reg),
                .out_next  (out_next[i])
            );
        end

        for (i = 0; i < dops_pkg::MASK_W; i++) begin : g_mask
            if (i < NUM_CHANNELS) begin : g_used
                assign out_mask_next[i] = out_next[i];
            end else begin : g_unused
                assign out_mask_next[i] = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_mask_reg <= out_mask_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, out_mask_reg[dops_pkg::MASK_W-1:1], 1'b0, out_mask_reg};

endmodule

// ===== hdl/dops_chan.sv =====
// ----------------------------------------------------------------------------
// dops_chan
// One power channel: output bit and seconds countdown, updated when an item
// is applied.
// ----------------------------------------------------------------------------
module dops_chan (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  dops_pkg::chan_ctl_t         ctl,
    input  logic                        delayed,
    input  logic [dops_pkg::CNT_W-1:0]  off_delay,
    output logic                        out_next
);

    logic                       out_reg;
    logic [dops_pkg::CNT_W-1:0] cnt_reg;
    logic [dops_pkg::CNT_W-1:0] cnt_next;
    logic                       delay_on;
    logic                       cnt_zero;
    logic                       cnt_one;

    assign delay_on = delayed && (off_delay != '0);
    assign cnt_zero = (cnt_reg == '0);
    assign cnt_one  = (cnt_reg == dops_pkg::CNT_W'(1));

    always_comb begin
        out_next = out_reg;
        cnt_next = cnt_reg;
        if (ctl.tick) begin
            if (!cnt_zero) begin
                if (cnt_one) begin
                    out_next = 1'b0;
                end
                cnt_next = cnt_reg - dops_pkg::CNT_W'(1);
            end
        end else if (ctl.hit) begin
            unique case (ctl.kind)
                dops_pkg::ACT_OFF: begin
                    if (delay_on) begin
                        if (cnt_zero) begin
                            cnt_next = off_delay;
                        end else if (cnt_one) begin
                            out_next = 1'b0;
                        end
                    end else begin
                        out_next = 1'b0;
                    end
                end
                dops_pkg::ACT_ON: begin
                    out_next = 1'b1;
                    cnt_next = '0;
                end
                dops_pkg::ACT_TOGGLE: begin
                    out_next = !out_reg;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg <= 1'b0;
            cnt_reg <= '0;
        end else if (en) begin
            out_reg <= out_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== hdl/dops_checker.sv =====
// ----------------------------------------------------------------------------
// dops_checker
// Port-level checks for the delayed-off power switch, bound to the top level.
// ----------------------------------------------------------------------------
module dops_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [dops_pkg::M_TDATA_W-1:0]  m_tdata
);

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_led0: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[6] == 1'b0))
        else $error("LED of channel 0 lit");

    a_led_mirror: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[11:7] == m_tdata[5:1]) && (m_tdata[15:12] == 4'b0000))
        else $error("LED mask does not mirror outputs");

endmodule

bind delayed_off_power_switch dops_checker u_dops_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
